// ===== sv/m7sap_pkg.sv =====
`timescale 1ns / 1ps
// m7sap_pkg: shared constants, types and saturation helpers for the mode-7
// scanline parameter pipeline; no dependencies

package m7sap_pkg;

    // scene geometry
    localparam int HORIZON_LINE      = 34;
    localparam int VIEW_DISTANCE     = 128;
    localparam int HALF_SCREEN_WIDTH = 120;
    localparam int LAST_VISIBLE_LINE = 159;
    localparam int FOG_MAX           = 14;
    localparam int FOG_DIVISOR       = 3;
    localparam int RECIP_NUM         = 1 << 16;

    // fixed-point shifts
    localparam int LAM_SHIFT  = 12;
    localparam int CS_SHIFT   = 8;
    localparam int STEP_SHIFT = 4;

    // field widths
    localparam int LINE_W   = 8;
    localparam int FOG_W    = 4;
    localparam int CAM_W    = 16;
    localparam int HEIGHT_W = 14;
    localparam int YAW_W    = 10;
    localparam int STEP_W   = 15;
    localparam int ORG_W    = 23;
    localparam int IDX_W    = 3;

    // derived datapath widths
    localparam int D_W     = $clog2(LAST_VISIBLE_LINE - HORIZON_LINE + 1);
    localparam int D_DEPTH = 1 << D_W;
    localparam int Q_W     = $clog2(RECIP_NUM + 1);
    localparam int LAM_W   = HEIGHT_W + Q_W - LAM_SHIFT;
    localparam int ROT_W   = LAM_W + YAW_W + 1 - CS_SHIFT;
    localparam int PA_W    = ROT_W - STEP_SHIFT;
    localparam int ACC_W   = 40;

    // divide by the fog divisor through a reciprocal multiply
    localparam int FOG_SHIFT = 10;
    localparam int FOG_RECIP = ((1 << FOG_SHIFT) + FOG_DIVISOR - 1) / FOG_DIVISOR;

    typedef enum logic [IDX_W-1:0] {
        REG_CAMERA_X      = 3'd0,
        REG_CAMERA_Y      = 3'd1,
        REG_CAMERA_HEIGHT = 3'd2,
        REG_YAW_SINE      = 3'd3,
        REG_YAW_COSINE    = 3'd4
    } cfg_reg_t;

    // control that travels with each pipeline stage
    typedef struct packed {
        logic             valid;
        logic             active;
        logic             ground;
        logic             affine;
        logic [FOG_W-1:0] fog;
    } m7_ctl_t;

    // per-frame camera settings
    typedef struct packed {
        logic [CAM_W-1:0]    cam_x;
        logic [CAM_W-1:0]    cam_y;
        logic [HEIGHT_W-1:0] height;
        logic [YAW_W-1:0]    yaw_sine;
        logic [YAW_W-1:0]    yaw_cosine;
    } m7_cfg_t;

    function automatic logic signed [STEP_W-1:0] sat_step(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [STEP_W-1:0] r;
        hi = ACC_W'((64'sd1 <<< (STEP_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        priority if (v > hi)
            r = hi[STEP_W-1:0];
        else if (v < lo)
            r = lo[STEP_W-1:0];
        else
            r = v[STEP_W-1:0];
        return r;
    endfunction

    function automatic logic signed [ORG_W-1:0] sat_org(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [ORG_W-1:0] r;
        hi = ACC_W'((64'sd1 <<< (ORG_W - 1)) - 64'sd1);
        lo = -hi - ACC_W'(1);
        priority if (v > hi)
            r = hi[ORG_W-1:0];
        else if (v < lo)
            r = lo[ORG_W-1:0];
        else
            r = v[ORG_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/mode7_scanline_affine_params.sv =====
`timescale 1ns / 1ps
// mode7_scanline_affine_params: top level of the mode-7 scanline parameter
// generator; depends on m7sap_pkg, m7sap_recip, m7sap_scale, m7sap_origin
//
// usage:
//   - s_axis carries one scanline number per transfer; m_axis returns one
//     result per scanline: fog level and affine terms in tdata, line-active
//     and ground-enable flags in tuser
//   - cfg writes camera x, camera y, height, yaw sine and yaw cosine by index;
//     cfg_ready is always high; write only while no line is in flight
//   - six register stages: classify/fog, reciprocal lookup, height multiply,
//     yaw rotation, origin terms, origin sum and saturation
//   - the input transfer edge loads the first stage, and m_axis_tvalid rises
//     once that line has reached the last stage
//   - throughput is one line per cycle while the receiver takes results; the
//     reciprocal table lookup and the one-multiply-per-stage split set the pipeline depth
//   - each stage has its own valid bit and loads whenever it is empty or the
//     stage after it moves, so bubbles collapse under a stall
//   - a stalled receiver holds the result steady; s_axis_tready falls only
//     once all six stages hold data
//   - reset empties the pipeline and loads camera 0,0, height 1024, yaw
//     sine 0 and cosine 256

module mode7_scanline_affine_params
    import m7sap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input scanline stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] line_number
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [79:0]       m_axis_tdata,   // [3:0] fog_level, [18:4] scale_a,
                                              // [33:19] shear_c, [56:34] origin_x,
                                              // [79:57] origin_y
    output logic [1:0]        m_axis_tuser,   // [0] line_active, [1] ground_enable
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [15:0]       cfg_data
);

    // camera registers
    logic [CAM_W-1:0]    cam_x_reg, cam_x_next;
    logic [CAM_W-1:0]    cam_y_reg, cam_y_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [YAW_W-1:0]    yaw_sine_reg, yaw_sine_next;
    logic [YAW_W-1:0]    yaw_cosine_reg, yaw_cosine_next;
    m7_cfg_t             cfg;

    // inter-stage links
    m7_ctl_t                  ctl_b, ctl_d, ctl_f;
    logic [Q_W-1:0]           q_b;
    logic signed [ROT_W-1:0]  cf_d, sf_d;
    logic                     rdy_scale, rdy_origin;
    logic signed [STEP_W-1:0] scale_a, shear_c;
    logic signed [ORG_W-1:0]  origin_x, origin_y;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cam_x_next      = cam_x_reg;
        cam_y_next      = cam_y_reg;
        height_next     = height_reg;
        yaw_sine_next   = yaw_sine_reg;
        yaw_cosine_next = yaw_cosine_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CAMERA_X:      cam_x_next      = cfg_data[CAM_W-1:0];
                REG_CAMERA_Y:      cam_y_next      = cfg_data[CAM_W-1:0];
                REG_CAMERA_HEIGHT: height_next     = cfg_data[HEIGHT_W-1:0];
                REG_YAW_SINE:      yaw_sine_next   = cfg_data[YAW_W-1:0];
                REG_YAW_COSINE:    yaw_cosine_next = cfg_data[YAW_W-1:0];
                default:           ; // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg      <= '0;
            cam_y_reg      <= '0;
            height_reg     <= HEIGHT_W'(1024);
            yaw_sine_reg   <= '0;
            yaw_cosine_reg <= YAW_W'(256);
        end
        else
        begin
            cam_x_reg      <= cam_x_next;
            cam_y_reg      <= cam_y_next;
            height_reg     <= height_next;
            yaw_sine_reg   <= yaw_sine_next;
            yaw_cosine_reg <= yaw_cosine_next;
        end
    end

    always_comb
    begin
        cfg.cam_x      = cam_x_reg;
        cfg.cam_y      = cam_y_reg;
        cfg.height     = height_reg;
        cfg.yaw_sine   = yaw_sine_reg;
        cfg.yaw_cosine = yaw_cosine_reg;
    end

    // stages one and two: classify the line, fog, reciprocal of distance
    m7sap_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .line      (s_axis_tdata),
        .out_ctl   (ctl_b),
        .out_q     (q_b),
        .out_ready (rdy_scale)
    );

    // stages three and four: height scale, then yaw rotation
    m7sap_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (ctl_b),
        .in_q      (q_b),
        .in_ready  (rdy_scale),
        .cfg       (cfg),
        .out_ctl   (ctl_d),
        .out_cf    (cf_d),
        .out_sf    (sf_d),
        .out_ready (rdy_origin)
    );

    // stages five and six: origin terms, sums, saturation, output register
    m7sap_origin u_origin (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctl       (ctl_d),
        .in_cf        (cf_d),
        .in_sf        (sf_d),
        .in_ready     (rdy_origin),
        .cfg          (cfg),
        .out_ctl      (ctl_f),
        .out_scale_a  (scale_a),
        .out_shear_c  (shear_c),
        .out_origin_x (origin_x),
        .out_origin_y (origin_y),
        .out_ready    (m_axis_tready)
    );

    assign m_axis_tvalid = ctl_f.valid;
    assign m_axis_tdata  = {origin_y, origin_x, shear_c, scale_a, ctl_f.fog};
    assign m_axis_tuser  = {ctl_f.ground, ctl_f.active};

endmodule

// ===== sv/m7sap_recip.sv =====
`timescale 1ns / 1ps
// m7sap_recip: line classification, fog level and reciprocal table lookup
// (two pipeline stages); depends on m7sap_pkg

module m7sap_recip
    import m7sap_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [LINE_W-1:0]    line,
    output m7_ctl_t              out_ctl,
    output logic [Q_W-1:0]       out_q,
    input  logic                 out_ready
);

    logic [Q_W-1:0] q_rom [D_DEPTH];

    // 65536 / d, with the horizon entry zero
    for (genvar g = 0; g < D_DEPTH; g++)
    begin : g_q_rom
        localparam int QV = (g == 0) ? 0 : RECIP_NUM / g;
        assign q_rom[g] = Q_W'(QV);
    end

    m7_ctl_t                   ctl_a_reg, ctl_a_next;
    m7_ctl_t                   ctl_b_reg;
    logic [D_W-1:0]            d_a_reg, d_a_next;
    logic [Q_W-1:0]            q_b_reg;
    logic                      rdy_a, rdy_b;

    logic                      active, above;
    logic [LINE_W-1:0]         d_full;
    logic signed [LINE_W+1:0]  fog_above;
    logic [LINE_W+FOG_SHIFT-1:0] fog_prod;
    logic [LINE_W-1:0]         fog_steps;
    logic [FOG_W-1:0]          fog_below;

    assign rdy_b    = !ctl_b_reg.valid || out_ready;
    assign rdy_a    = !ctl_a_reg.valid || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        active    = line <= LINE_W'(LAST_VISIBLE_LINE);
        above     = line < LINE_W'(HORIZON_LINE);
        d_full    = line - LINE_W'(HORIZON_LINE);
        fog_above = $signed({2'b00, line}) - (LINE_W + 2)'(HORIZON_LINE - FOG_MAX);
        fog_prod  = (LINE_W + FOG_SHIFT)'(d_full) * (LINE_W + FOG_SHIFT)'(FOG_RECIP);
        fog_steps = fog_prod[LINE_W+FOG_SHIFT-1:FOG_SHIFT];
        fog_below = (fog_steps >= LINE_W'(FOG_MAX)) ? '0
                    : FOG_W'(LINE_W'(FOG_MAX) - fog_steps);

        ctl_a_next.valid  = in_valid;
        ctl_a_next.active = active;
        ctl_a_next.ground = active && !above;
        ctl_a_next.affine = active && !above && (d_full != '0);
        if (!active)
            ctl_a_next.fog = '0;
        else if (above)
            ctl_a_next.fog = (fog_above < 0) ? '0 : fog_above[FOG_W-1:0];
        else
            ctl_a_next.fog = fog_below;
        d_a_next = d_full[D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            if (rdy_a)
                ctl_a_reg <= ctl_a_next;
            if (rdy_b)
                ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
            d_a_reg <= d_a_next;
        if (rdy_b && ctl_a_reg.valid)
            q_b_reg <= q_rom[d_a_reg];
    end

    assign out_ctl = ctl_b_reg;
    assign out_q   = q_b_reg;

endmodule

// ===== sv/m7sap_scale.sv =====
`timescale 1ns / 1ps
// m7sap_scale: height scaling and yaw rotation multipliers (two pipeline
// stages); depends on m7sap_pkg

module m7sap_scale
    import m7sap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  m7_ctl_t                 in_ctl,
    input  logic [Q_W-1:0]          in_q,
    output logic                    in_ready,
    input  m7_cfg_t                 cfg,
    output m7_ctl_t                 out_ctl,
    output logic signed [ROT_W-1:0] out_cf,
    output logic signed [ROT_W-1:0] out_sf,
    input  logic                    out_ready
);

    m7_ctl_t                    ctl_c_reg, ctl_d_reg;
    logic [LAM_W-1:0]           lam_c_reg, lam_c_next;
    logic signed [ROT_W-1:0]    cf_d_reg, cf_d_next;
    logic signed [ROT_W-1:0]    sf_d_reg, sf_d_next;
    logic                       rdy_c, rdy_d;

    logic [HEIGHT_W+Q_W-1:0]    lam_prod;
    logic signed [LAM_W+YAW_W:0] cos_prod, sin_prod;

    assign rdy_d    = !ctl_d_reg.valid || out_ready;
    assign rdy_c    = !ctl_c_reg.valid || rdy_d;
    assign in_ready = rdy_c;

    always_comb
    begin
        lam_prod   = (HEIGHT_W + Q_W)'(cfg.height) * (HEIGHT_W + Q_W)'(in_q);
        lam_c_next = lam_prod[HEIGHT_W+Q_W-1:LAM_SHIFT];
        // arithmetic shift right by taking the upper bits
        cos_prod   = (LAM_W + YAW_W + 1)'($signed({1'b0, lam_c_reg}))
                     * (LAM_W + YAW_W + 1)'($signed(cfg.yaw_cosine));
        sin_prod   = (LAM_W + YAW_W + 1)'($signed({1'b0, lam_c_reg}))
                     * (LAM_W + YAW_W + 1)'($signed(cfg.yaw_sine));
        cf_d_next  = cos_prod[LAM_W+YAW_W:CS_SHIFT];
        sf_d_next  = sin_prod[LAM_W+YAW_W:CS_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
        end
        else
        begin
            if (rdy_c)
                ctl_c_reg <= in_ctl;
            if (rdy_d)
                ctl_d_reg <= ctl_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c && in_ctl.valid)
            lam_c_reg <= lam_c_next;
        if (rdy_d && ctl_c_reg.valid)
        begin
            cf_d_reg <= cf_d_next;
            sf_d_reg <= sf_d_next;
        end
    end

    assign out_ctl = ctl_d_reg;
    assign out_cf  = cf_d_reg;
    assign out_sf  = sf_d_reg;

endmodule

// ===== sv/m7sap_origin.sv =====
`timescale 1ns / 1ps
// m7sap_origin: step terms, line-start origin sums and saturation into the
// output register (two pipeline stages); depends on m7sap_pkg

module m7sap_origin
    import m7sap_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  m7_ctl_t                  in_ctl,
    input  logic signed [ROT_W-1:0]  in_cf,
    input  logic signed [ROT_W-1:0]  in_sf,
    output logic                     in_ready,
    input  m7_cfg_t                  cfg,
    output m7_ctl_t                  out_ctl,
    output logic signed [STEP_W-1:0] out_scale_a,
    output logic signed [STEP_W-1:0] out_shear_c,
    output logic signed [ORG_W-1:0]  out_origin_x,
    output logic signed [ORG_W-1:0]  out_origin_y,
    input  logic                     out_ready
);

    localparam logic signed [ACC_W-1:0] HALF_S = ACC_W'(HALF_SCREEN_WIDTH);
    localparam logic signed [ACC_W-1:0] VIEW_S = ACC_W'(VIEW_DISTANCE);

    m7_ctl_t                    ctl_e_reg, ctl_f_reg;
    logic signed [PA_W-1:0]     pa_e_reg, pa_e_next;
    logic signed [PA_W-1:0]     pc_e_reg, pc_e_next;
    logic signed [ACC_W-1:0]    hx_e_reg, hx_e_next;   // half width times pa
    logic signed [ACC_W-1:0]    hy_e_reg, hy_e_next;   // half width times pc
    logic signed [ACC_W-1:0]    vx_e_reg, vx_e_next;   // view distance times sf
    logic signed [ACC_W-1:0]    vy_e_reg, vy_e_next;   // view distance times cf
    logic signed [STEP_W-1:0]   sa_f_reg, sa_f_next;
    logic signed [STEP_W-1:0]   sc_f_reg, sc_f_next;
    logic signed [ORG_W-1:0]    ox_f_reg, ox_f_next;
    logic signed [ORG_W-1:0]    oy_f_reg, oy_f_next;
    logic                       rdy_e, rdy_f;

    logic signed [ACC_W-1:0]    cx_s, cy_s, sum_x, sum_y;

    assign rdy_f    = !ctl_f_reg.valid || out_ready;
    assign rdy_e    = !ctl_e_reg.valid || rdy_f;
    assign in_ready = rdy_e;

    always_comb
    begin
        pa_e_next = in_cf[ROT_W-1:STEP_SHIFT];
        pc_e_next = in_sf[ROT_W-1:STEP_SHIFT];
        hx_e_next = ACC_W'(pa_e_next) * HALF_S;
        hy_e_next = ACC_W'(pc_e_next) * HALF_S;
        vx_e_next = (ACC_W'(in_sf) * VIEW_S) >>> STEP_SHIFT;
        vy_e_next = (ACC_W'(in_cf) * VIEW_S) >>> STEP_SHIFT;

        cx_s  = $signed(ACC_W'(cfg.cam_x));
        cy_s  = $signed(ACC_W'(cfg.cam_y));
        sum_x = cx_s - hx_e_reg + vx_e_reg;
        sum_y = cy_s - hy_e_reg - vy_e_reg;

        // horizon, sky and blanking lines carry no affine terms
        if (ctl_e_reg.affine)
        begin
            sa_f_next = sat_step(ACC_W'(pa_e_reg));
            sc_f_next = sat_step(ACC_W'(pc_e_reg));
            ox_f_next = sat_org(sum_x);
            oy_f_next = sat_org(sum_y);
        end
        else
        begin
            sa_f_next = '0;
            sc_f_next = '0;
            ox_f_next = '0;
            oy_f_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_e_reg <= '0;
            ctl_f_reg <= '0;
        end
        else
        begin
            if (rdy_e)
                ctl_e_reg <= in_ctl;
            if (rdy_f)
                ctl_f_reg <= ctl_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_e && in_ctl.valid)
        begin
            pa_e_reg <= pa_e_next;
            pc_e_reg <= pc_e_next;
            hx_e_reg <= hx_e_next;
            hy_e_reg <= hy_e_next;
            vx_e_reg <= vx_e_next;
            vy_e_reg <= vy_e_next;
        end
        if (rdy_f && ctl_e_reg.valid)
        begin
            sa_f_reg <= sa_f_next;
            sc_f_reg <= sc_f_next;
            ox_f_reg <= ox_f_next;
            oy_f_reg <= oy_f_next;
        end
    end

    assign out_ctl      = ctl_f_reg;
    assign out_scale_a  = sa_f_reg;
    assign out_shear_c  = sc_f_reg;
    assign out_origin_x = ox_f_reg;
    assign out_origin_y = oy_f_reg;

endmodule

// ===== sv/m7sap_checker.sv =====
`timescale 1ns / 1ps
// m7sap_checker: port-level assertions for the mode-7 scanline parameter
// block and the bind that attaches them; depends on m7sap_pkg

module m7sap_checker
    import m7sap_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds steady
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // input side only backs up when the output is stalled with data
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // blanking lines carry an all-zero result
    a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("blanking line with nonzero result");

    // sky lines carry fog only
    a_sky_fog_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1] |-> m_axis_tdata[79:4] == '0)
        else $error("sky line with affine terms");

    // fog never exceeds its maximum
    a_fog_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[FOG_W-1:0] <= FOG_W'(FOG_MAX))
        else $error("fog level out of range");

endmodule

bind mode7_scanline_affine_params m7sap_checker u_checker (.*);
